// ----- rtl/pwf_pkg.sv -----
// ----------------------------------------------------------------------------
// pwf_pkg
// Types and constants shared by the polyline waypoint follower.
// ----------------------------------------------------------------------------
package pwf_pkg;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 16;
    localparam int CNT_W   = 9;
    localparam int SUM_W   = 48;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_POINT_COUNT  = 2'd0,
        REG_TRAVEL_SPEED = 2'd1,
        REG_START_OFFSET = 2'd2,
        REG_SNAP_FIRST   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [7:0]                  point_index;
        logic signed [COORD_W-1:0]   coord_x;
        logic signed [COORD_W-1:0]   coord_y;
        logic signed [COORD_W-1:0]   coord_z;
        logic [15:0]                 elapsed_ms;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]   pos_x;
        logic signed [COORD_W-1:0]   pos_y;
        logic signed [COORD_W-1:0]   pos_z;
        logic signed [DIR_W-1:0]     dir_x;
        logic signed [DIR_W-1:0]     dir_y;
        logic signed [DIR_W-1:0]     dir_z;
        logic                        new_segment;
        logic                        finished;
        logic [SUM_W-1:0]            travelled;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TICK_MUL,
        ST_TICK_SAT,
        ST_SNAP_RD,
        ST_SNAP_WT,
        ST_BEGIN,
        ST_SEG_RDA,
        ST_SEG_RDB,
        ST_SEG_WT,
        ST_SEG_DIFF,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_LIM_MUL,
        ST_LIM_WT,
        ST_ROOT,
        ST_DECIDE,
        ST_MOVE_MUL,
        ST_MOVE_LD,
        ST_MOVE_DIV,
        ST_MOVE_ST,
        ST_DIR_LD,
        ST_DIR_DIV,
        ST_DIR_ST,
        ST_FINISH
    } state_t;

    // where the current segment starts
    typedef enum logic [1:0] {
        MODE_FIRST,   // from the current position
        MODE_LOOP,    // from the previous waypoint
        MODE_LAST     // last segment of the table, path end reached
    } seg_mode_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

endpackage

// ----- rtl/polyline_waypoint_follower.sv -----
// ----------------------------------------------------------------------------
// polyline_waypoint_follower
// Moves a point along a 3-D polyline held in an on-chip waypoint table.
// ----------------------------------------------------------------------------
// A load transaction writes one waypoint and finishes at once (busy stays low).
// Start and tick transactions each give one result, presented for exactly one
// cycle with done high; the receiver cannot stall it. busy stays high from the
// accepting edge until the result cycle. One 33x33 multiplier, one restoring
// divider and one square-root step unit are shared under the sequencer.
// Sequence, from the accepting edge: a tick first multiplies and saturates its
// step, and a start that snaps first reads waypoint zero; then both begin. The
// first segment is measured, ending in a square root; each waypoint passed
// measures the next segment, and running off the end measures the last one.
// Placing the point inside a segment takes three divides of 33 quotient bits,
// the direction three divides of 15 quotient bits, skipped for a zero-length
// segment. A finish state follows, and done is high in the cycle after it.
// An advance that is already past the end goes straight from the begin state
// to the finish.
// cfg_ready is tied high; write the registers only while busy is low and no
// result is pending, since the walk reads them throughout.
module polyline_waypoint_follower #(
    parameter int MAX_POINTS = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pwf_pkg::item_t    item,
    output logic              done,
    output pwf_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import pwf_pkg::*;

    localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    // waypoint table
    logic signed [31:0] way_x_mem [MAX_POINTS];
    logic signed [31:0] way_y_mem [MAX_POINTS];
    logic signed [31:0] way_z_mem [MAX_POINTS];
    logic signed [31:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    // configuration
    logic [CNT_W-1:0]   point_count_reg;
    logic [31:0]        travel_speed_reg;
    logic [30:0]        start_offset_reg;
    logic               snap_first_reg;
    logic [CNT_W-1:0]   count;

    // path state
    logic signed [31:0] cur_reg [3];
    logic [CNT_W-1:0]   seg_idx_reg;
    logic [SUM_W-1:0]   dist_sum_reg;

    // work registers
    state_t             state_reg, state_next;
    seg_mode_t          mode_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [31:0]        step_reg;
    logic [15:0]        elapsed_reg;
    logic signed [31:0] a_reg [3];
    logic signed [31:0] b_reg [3];
    logic signed [32:0] d_reg [3];
    logic [1:0]         k_reg;
    logic [65:0]        sq_reg;
    logic               pass_reg;
    logic               fresh_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] dir_reg [3];
    logic               done_reg;
    result_t            res_reg;

    // shared multiplier
    logic [32:0]        mul_a, mul_b;
    logic [65:0]        prod_reg;

    // square-root unit
    logic [65:0]        rad_reg;
    logic [32:0]        root_reg;    // segment length once the root is done
    logic [34:0]        rrem_reg;
    logic [36:0]        rt_sh, rt_trial;
    logic               rt_ge;

    // divider unit
    logic [32:0]        div_rem_reg;
    logic [65:0]        div_num_reg;
    logic [32:0]        quo_reg;
    logic [33:0]        dv_t;
    logic               dv_ge;
    logic [5:0]         cnt_reg;

    logic [32:0]        mag_k;
    logic [47:0]        dir_num;
    logic [48:0]        sum_ext;

    assign count = (point_count_reg < CNT_W'(2)) ? CNT_W'(2) :
                   (32'(point_count_reg) > MAX_POINTS) ? CNT_W'(MAX_POINTS) :
                   point_count_reg;

    assign mag_k   = mag33(d_reg[k_reg]);
    assign dir_num = {1'b0, mag_k, 14'b0} + 48'(root_reg >> 1);
    assign sum_ext = {1'b0, dist_sum_reg} + 49'(step_reg);

    assign rt_sh    = {rrem_reg, rad_reg[65:64]};
    assign rt_trial = {2'b00, root_reg, 2'b01};
    assign rt_ge    = rt_sh >= rt_trial;

    assign dv_t  = {div_rem_reg, div_num_reg[65]};
    assign dv_ge = dv_t >= {1'b0, root_reg};

    assign wr_en = start && !busy && (item.cmd == CMD_LOAD) &&
                   (32'(item.point_index) < MAX_POINTS);

    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    // ------------------------------------------------------------------
    // control outputs: busy, table address, multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        busy    = (state_reg != ST_IDLE);
        rd_addr = '0;
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            ST_SEG_RDA:
            begin
                rd_addr = (mode_reg == MODE_LAST) ? AW'(count - CNT_W'(2))
                                                  : AW'(idx_reg - CNT_W'(1));
            end
            ST_SEG_RDB:
            begin
                rd_addr = (mode_reg == MODE_LAST) ? AW'(count - CNT_W'(1))
                                                  : AW'(idx_reg);
            end
            ST_TICK_MUL:
            begin
                mul_a = 33'(travel_speed_reg);
                mul_b = 33'(elapsed_reg);
            end
            ST_SQ_MUL:
            begin
                mul_a = mag_k;
                mul_b = mag_k;
            end
            ST_LIM_MUL:
            begin
                mul_a = 33'(step_reg);
                mul_b = 33'(step_reg);
            end
            ST_MOVE_MUL:
            begin
                mul_a = mag_k;
                mul_b = 33'(step_reg);
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (item.cmd == CMD_START))
                    state_next = snap_first_reg ? ST_SNAP_RD : ST_BEGIN;
                else if (start && (item.cmd == CMD_TICK))
                    state_next = ST_TICK_MUL;
            end
            ST_TICK_MUL: state_next = ST_TICK_SAT;
            ST_TICK_SAT: state_next = ST_BEGIN;
            ST_SNAP_RD:  state_next = ST_SNAP_WT;
            ST_SNAP_WT:  state_next = ST_BEGIN;
            ST_BEGIN:
            begin
                if (seg_idx_reg >= count || seg_idx_reg == '0)
                    state_next = ST_FINISH;
                else
                    state_next = ST_SEG_RDB;
            end
            ST_SEG_RDA:  state_next = ST_SEG_RDB;
            ST_SEG_RDB:  state_next = ST_SEG_WT;
            ST_SEG_WT:   state_next = ST_SEG_DIFF;
            ST_SEG_DIFF: state_next = ST_SQ_MUL;
            ST_SQ_MUL:   state_next = ST_SQ_ACC;
            ST_SQ_ACC:   state_next = (k_reg == 2'd2) ? ST_LIM_MUL : ST_SQ_MUL;
            ST_LIM_MUL:  state_next = ST_LIM_WT;
            ST_LIM_WT:   state_next = ST_ROOT;
            ST_ROOT:     state_next = (cnt_reg == '0) ? ST_DECIDE : ST_ROOT;
            ST_DECIDE:
            begin
                if (mode_reg == MODE_LAST)
                    state_next = ST_DIR_LD;
                else if (!pass_reg)
                    state_next = ST_MOVE_MUL;
                else
                    state_next = ST_SEG_RDA;
            end
            ST_MOVE_MUL: state_next = ST_MOVE_LD;
            ST_MOVE_LD:  state_next = ST_MOVE_DIV;
            ST_MOVE_DIV: state_next = (cnt_reg == '0) ? ST_MOVE_ST : ST_MOVE_DIV;
            ST_MOVE_ST:  state_next = (k_reg == 2'd2) ? ST_DIR_LD : ST_MOVE_MUL;
            ST_DIR_LD:   state_next = (root_reg == '0) ? ST_DIR_ST : ST_DIR_DIV;
            ST_DIR_DIV:  state_next = (cnt_reg == '0) ? ST_DIR_ST : ST_DIR_DIV;
            ST_DIR_ST:   state_next = (k_reg == 2'd2) ? ST_FINISH : ST_DIR_LD;
            ST_FINISH:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // waypoint table, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            way_x_mem[AW'(item.point_index)] <= item.coord_x;
            way_y_mem[AW'(item.point_index)] <= item.coord_y;
            way_z_mem[AW'(item.point_index)] <= item.coord_z;
        end
        rd_x_reg <= way_x_mem[rd_addr];
        rd_y_reg <= way_y_mem[rd_addr];
        rd_z_reg <= way_z_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= CNT_W'(2);
            travel_speed_reg <= '0;
            start_offset_reg <= '0;
            snap_first_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_POINT_COUNT:  point_count_reg  <= cfg_data[CNT_W-1:0];
                REG_TRAVEL_SPEED: travel_speed_reg <= cfg_data;
                REG_START_OFFSET: start_offset_reg <= cfg_data[30:0];
                REG_SNAP_FIRST:   snap_first_reg   <= cfg_data[0];
                default:          snap_first_reg   <= snap_first_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // path state and result
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                cur_reg[i] <= '0;
            seg_idx_reg  <= CNT_W'(1);
            dist_sum_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (state_reg == ST_IDLE && start && item.cmd == CMD_START)
                seg_idx_reg <= CNT_W'(1);
            if (state_reg == ST_SNAP_WT)
            begin
                cur_reg[0] <= rd_x_reg;
                cur_reg[1] <= rd_y_reg;
                cur_reg[2] <= rd_z_reg;
            end
            if (state_reg == ST_BEGIN)
                dist_sum_reg <= sum_ext[48] ? '1 : sum_ext[47:0];
            if (state_reg == ST_DECIDE)
            begin
                if (mode_reg == MODE_LAST)
                    seg_idx_reg <= count;
                else if (!pass_reg && mode_reg == MODE_LOOP)
                    seg_idx_reg <= idx_reg;
            end
            if (state_reg == ST_FINISH)
            begin
                for (int i = 0; i < 3; i++)
                    cur_reg[i] <= pos_reg[i];
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FINISH)
        begin
            res_reg.pos_x       <= pos_reg[0];
            res_reg.pos_y       <= pos_reg[1];
            res_reg.pos_z       <= pos_reg[2];
            res_reg.dir_x       <= dir_reg[0];
            res_reg.dir_y       <= dir_reg[1];
            res_reg.dir_z       <= dir_reg[2];
            res_reg.new_segment <= fresh_reg;
            res_reg.finished    <= (seg_idx_reg >= count);
            res_reg.travelled   <= dist_sum_reg;
        end
    end

    // ------------------------------------------------------------------
    // datapath: segment walk, shared multiplier, root and divide steps
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                step_reg    <= {1'b0, start_offset_reg};
                elapsed_reg <= item.elapsed_ms;
            end
            ST_TICK_SAT:
            begin
                step_reg <= (prod_reg[65:32] != '0) ? '1 : prod_reg[31:0];
            end
            ST_BEGIN:
            begin
                idx_reg   <= seg_idx_reg;
                mode_reg  <= MODE_FIRST;
                fresh_reg <= 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    a_reg[i]   <= cur_reg[i];
                    pos_reg[i] <= cur_reg[i];
                    dir_reg[i] <= '0;
                end
            end
            ST_SEG_RDB:
            begin
                if (mode_reg != MODE_FIRST)
                begin
                    a_reg[0] <= rd_x_reg;
                    a_reg[1] <= rd_y_reg;
                    a_reg[2] <= rd_z_reg;
                end
            end
            ST_SEG_WT:
            begin
                b_reg[0] <= rd_x_reg;
                b_reg[1] <= rd_y_reg;
                b_reg[2] <= rd_z_reg;
            end
            ST_SEG_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                    d_reg[i] <= {b_reg[i][31], b_reg[i]} - {a_reg[i][31], a_reg[i]};
                sq_reg <= '0;
                k_reg  <= 2'd0;
            end
            ST_SQ_ACC:
            begin
                sq_reg <= sq_reg + prod_reg;
                k_reg  <= k_reg + 2'd1;
            end
            ST_LIM_WT:
            begin
                // waypoint reached when its squared distance fits in step^2
                pass_reg <= !(sq_reg > prod_reg);
                rad_reg  <= sq_reg;
                root_reg <= '0;
                rrem_reg <= '0;
                cnt_reg  <= 6'd32;
            end
            ST_ROOT:
            begin
                rrem_reg <= rt_ge ? 35'(rt_sh - rt_trial) : 35'(rt_sh);
                root_reg <= {root_reg[31:0], rt_ge};
                rad_reg  <= {rad_reg[63:0], 2'b00};
                cnt_reg  <= cnt_reg - 6'd1;
            end
            ST_DECIDE:
            begin
                k_reg <= 2'd0;
                if (mode_reg == MODE_LAST)
                begin
                    fresh_reg <= 1'b1;
                    for (int i = 0; i < 3; i++)
                        pos_reg[i] <= b_reg[i];
                end
                else if (!pass_reg)
                begin
                    fresh_reg <= (mode_reg == MODE_LOOP);
                end
                else
                begin
                    step_reg <= step_reg - root_reg[31:0];
                    idx_reg  <= idx_reg + CNT_W'(1);
                    mode_reg <= (idx_reg + CNT_W'(1) < count) ? MODE_LOOP : MODE_LAST;
                end
            end
            ST_MOVE_LD:
            begin
                div_rem_reg <= prod_reg[65:33];
                div_num_reg <= {prod_reg[32:0], 33'b0};
                quo_reg     <= '0;
                cnt_reg     <= 6'd32;
            end
            ST_MOVE_DIV, ST_DIR_DIV:
            begin
                div_rem_reg <= dv_ge ? 33'(dv_t - {1'b0, root_reg}) : dv_t[32:0];
                div_num_reg <= {div_num_reg[64:0], 1'b0};
                quo_reg     <= {quo_reg[31:0], dv_ge};
                cnt_reg     <= cnt_reg - 6'd1;
            end
            ST_MOVE_ST:
            begin
                pos_reg[k_reg] <= d_reg[k_reg][32] ? a_reg[k_reg] - quo_reg[31:0]
                                                   : a_reg[k_reg] + quo_reg[31:0];
                // direction pass restarts at component x
                k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
            end
            ST_DIR_LD:
            begin
                // numerator |d| * 16384 + len/2, quotient fits 15 bits
                div_rem_reg <= 33'(dir_num >> 15);
                div_num_reg <= {dir_num[14:0], 51'b0};
                quo_reg     <= '0;
                cnt_reg     <= 6'd14;
            end
            ST_DIR_ST:
            begin
                dir_reg[k_reg] <= d_reg[k_reg][32] ? -16'(quo_reg) : 16'(quo_reg);
                k_reg <= k_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_busy_after_move: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd == CMD_START || item.cmd == CMD_TICK)) |=> busy)
        else $error("start or tick transaction did not raise busy");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIR_DIV || state_reg == ST_MOVE_DIV) |-> root_reg != '0)
        else $error("divide by zero segment length");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEG_RDB && mode_reg != MODE_LAST) |-> idx_reg < count)
        else $error("segment index beyond point count");

    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_FINISH))
        else $error("result strobe outside finish");

endmodule

// ----- tb/tb_polyline_waypoint_follower.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyline_waypoint_follower
// Self-checking bench for the polyline waypoint follower: loads waypoint
// tables, starts paths and ticks them along, predicting every position,
// direction, flag and distance total in-bench and comparing each result.
// ----------------------------------------------------------------------------
module tb_polyline_waypoint_follower;
    import pwf_pkg::*;

    localparam int          TABLE_DEPTH  = 256;
    localparam int          ITEM_TARGET  = 1050;
    localparam int          IDLE_PCT     = 37;
    localparam int          SETTLE_CYC   = 20;     // quiet cycles before a config write
    localparam int          STALL_LIMIT  = 400000; // cycles with no transaction at all
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [63:0] STEP_MAX     = 64'hFFFF_FFFF;
    localparam logic [48:0] TRAVEL_MAX   = 49'hFFFF_FFFF_FFFF;
    localparam logic [15:0] DIR_UNIT     = 16'd16384;

    typedef longint vec3_t [3];

    // work queued for the driver: an item, a register write, or a pause
    // until the block is fully quiet
    typedef enum {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;
    typedef struct {
        op_kind_t    kind;
        item_t       itm;
        reg_idx_t    ridx;
        logic [31:0] data;
    } pending_op_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    polyline_waypoint_follower dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pending_op_t todo_q [$];
    result_t     expected_moves [$];

    // in-bench copy of the path state and registers
    logic [31:0] path_x [TABLE_DEPTH];
    logic [31:0] path_y [TABLE_DEPTH];
    logic [31:0] path_z [TABLE_DEPTH];
    logic [31:0] here_x, here_y, here_z;
    int unsigned aim_idx;
    logic [47:0] odometer;
    logic [8:0]  n_points;
    logic [31:0] speed_q16;
    logic [30:0] offset_q16;
    logic        snap_mode;

    int mismatches;
    int items_sent;
    int n_loads, n_starts, n_ticks, n_results, n_passed, n_ended, n_cfg;
    int quiet_cnt;
    int stall_cnt;
    int accepted_items;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Path arithmetic
    // ------------------------------------------------------------------------
    function automatic logic [63:0] abs64(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic int unsigned span_points();
        if (n_points < 9'd2)
            return 2;
        if (n_points > 9'(TABLE_DEPTH))
            return TABLE_DEPTH;
        return int'(n_points);
    endfunction

    function automatic vec3_t waypoint(input int unsigned i);
        vec3_t p;
        p[0] = longint'($signed(path_x[i]));
        p[1] = longint'($signed(path_y[i]));
        p[2] = longint'($signed(path_z[i]));
        return p;
    endfunction

    // floor square root; the length never needs more than 35 bits
    function automatic logic [63:0] floor_root(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = '0;
        for (int b = 34; b >= 0; b--)
        begin
            c = 128'(r | (64'd1 << b));
            if (c * c <= n)
                r = c[63:0];
        end
        return r;
    endfunction

    function automatic void measure_leg(input vec3_t a, input vec3_t b, output vec3_t d,
                                        output logic [127:0] sq, output logic [63:0] len);
        logic [127:0] m;
        sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            d[k] = b[k] - a[k];
            m    = 128'(abs64(d[k]));
            sq   = sq + m * m;
        end
        len = floor_root(sq);
    endfunction

    // rounded unit vector, zero for a degenerate leg
    function automatic vec3_t heading(input vec3_t d, input logic [63:0] len);
        vec3_t       h;
        logic [63:0] m;
        for (int k = 0; k < 3; k++)
        begin
            if (len == 0)
                h[k] = 0;
            else
            begin
                m    = (abs64(d[k]) * 64'(DIR_UNIT) + len / 2) / len;
                h[k] = (d[k] < 0) ? -longint'(m) : longint'(m);
            end
        end
        return h;
    endfunction

    // the product is kept to 64 bits, narrower than the block's 66-bit product
    function automatic vec3_t partway(input vec3_t a, input vec3_t d, input logic [63:0] len,
                                      input logic [63:0] step);
        vec3_t       p;
        logic [63:0] m;
        for (int k = 0; k < 3; k++)
        begin
            m    = (abs64(d[k]) * step) / len;
            p[k] = (d[k] < 0) ? a[k] - longint'(m) : a[k] + longint'(m);
        end
        return p;
    endfunction

    // walk the polyline by step; updates the position and the aimed waypoint
    function automatic void walk_path(input logic [63:0] step, output vec3_t pos,
                                      output vec3_t dir, output logic passed);
        int unsigned  cnt;
        int unsigned  idx;
        vec3_t        p, a, b, d;
        logic [127:0] sq;
        logic [63:0]  len;
        logic         placed;
        cnt    = span_points();
        idx    = aim_idx;
        placed = 1'b0;
        p[0]   = longint'($signed(here_x));
        p[1]   = longint'($signed(here_y));
        p[2]   = longint'($signed(here_z));
        passed = 1'b0;
        if (idx >= cnt || idx == 0)
        begin
            // already at the end: hold, no direction
            pos = p;
            dir = '{0, 0, 0};
            return;
        end
        b = waypoint(idx);
        measure_leg(p, b, d, sq, len);
        if (sq > 128'(step) * 128'(step))
        begin
            pos    = partway(p, d, len, step);
            dir    = heading(d, len);
            placed = 1'b1;
        end
        else
        begin
            step   = step - len;
            passed = 1'b1;
            idx++;
            while (idx < cnt && !placed)
            begin
                a = waypoint(idx - 1);
                b = waypoint(idx);
                measure_leg(a, b, d, sq, len);
                if (sq > 128'(step) * 128'(step))
                begin
                    pos     = partway(a, d, len, step);
                    dir     = heading(d, len);
                    aim_idx = idx;
                    placed  = 1'b1;
                end
                else
                begin
                    step = step - len;
                    idx++;
                end
            end
            if (!placed)
            begin
                // ran off the end: park on the last waypoint
                a = waypoint(cnt - 2);
                b = waypoint(cnt - 1);
                measure_leg(a, b, d, sq, len);
                dir     = heading(d, len);
                pos     = b;
                aim_idx = cnt;
            end
        end
        here_x = pos[0][31:0];
        here_y = pos[1][31:0];
        here_z = pos[2][31:0];
    endfunction

    // state update for one accepted transaction; returns 1 when it yields a result
    function automatic logic predict_move(input item_t it, output result_t r);
        logic [63:0] step;
        logic [48:0] sum;
        vec3_t       pos, dir;
        logic        passed;
        r = '0;
        case (it.cmd)
            CMD_LOAD:
            begin
                path_x[it.point_index] = it.coord_x;
                path_y[it.point_index] = it.coord_y;
                path_z[it.point_index] = it.coord_z;
                return 1'b0;
            end
            CMD_START:
            begin
                aim_idx = 1;
                if (snap_mode)
                begin
                    here_x = path_x[0];
                    here_y = path_y[0];
                    here_z = path_z[0];
                end
                step = 64'(offset_q16);
            end
            CMD_TICK:
            begin
                step = 64'(speed_q16) * 64'(it.elapsed_ms);
                if (step > STEP_MAX)
                    step = STEP_MAX;
            end
            default:
                return 1'b0;
        endcase
        walk_path(step, pos, dir, passed);
        sum = 49'(odometer) + 49'(step);
        if (sum > TRAVEL_MAX)
            sum = TRAVEL_MAX;
        odometer      = sum[47:0];
        r.pos_x       = pos[0][31:0];
        r.pos_y       = pos[1][31:0];
        r.pos_z       = pos[2][31:0];
        r.dir_x       = dir[0][15:0];
        r.dir_y       = dir[1][15:0];
        r.dir_z       = dir[2][15:0];
        r.new_segment = passed;
        r.finished    = (aim_idx >= span_points());
        r.travelled   = odometer;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] pick_coord();
        // mostly a few units around the origin so that legs get crossed
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'($urandom_range(0, 40 << 16)) - 32'(20 << 16);
    endfunction

    task automatic queue_item(input logic [1:0] cmd, input logic [7:0] slot,
                              input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [15:0] ms);
        pending_op_t op;
        op.kind             = OP_ITEM;
        op.itm.cmd          = cmd;
        op.itm.point_index  = slot;
        op.itm.coord_x      = x;
        op.itm.coord_y      = y;
        op.itm.coord_z      = z;
        op.itm.elapsed_ms   = ms;
        op.ridx             = REG_POINT_COUNT;
        op.data             = '0;
        todo_q.push_back(op);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // fields a command does not use still carry random bits
    task automatic queue_load(input logic [7:0] slot, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
        queue_item(CMD_LOAD, slot, x, y, z, 16'($urandom));
    endtask

    task automatic queue_start();
        queue_item(CMD_START, 8'($urandom), $urandom, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic queue_tick(input logic [15:0] ms);
        queue_item(CMD_TICK, 8'($urandom), $urandom, $urandom, $urandom, ms);
    endtask

    task automatic queue_cfg(input reg_idx_t ridx, input logic [31:0] data);
        pending_op_t op;
        op.kind = OP_CFG;
        op.itm  = '0;
        op.ridx = ridx;
        op.data = data;
        todo_q.push_back(op);
    endtask

    task automatic queue_drain();
        pending_op_t op;
        op.kind = OP_DRAIN;
        op.itm  = '0;
        op.ridx = REG_POINT_COUNT;
        op.data = '0;
        todo_q.push_back(op);
    endtask

    function automatic logic [15:0] pick_ms();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            2:       return 16'd0;
            default: return 16'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [31:0] pick_count();
        case ($urandom_range(15))
            0:       return {$urandom_range(0, 8'hFF) << 9} | 32'd0;
            1:       return 32'd1;
            2:       return 32'd256;
            3:       return 32'd511;
            4:       return 32'd255;
            5:       return $urandom;
            default: return ($urandom & 32'hFFFF_FE00) | 32'($urandom_range(2, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------
    initial
    begin
        logic first;
        int   n_steps;
        first      = 1'b1;
        items_sent = 0;

        // directed: a four-point path with a zero-length leg and an extreme far point
        queue_cfg(REG_POINT_COUNT, 32'd4);
        queue_cfg(REG_TRAVEL_SPEED, 32'h0001_0000);
        queue_cfg(REG_START_OFFSET, 32'd0);
        queue_cfg(REG_SNAP_FIRST, 32'd1);
        queue_load(8'd0, 32'd0, 32'd0, 32'd0);
        queue_load(8'd1, 32'(3 << 16), 32'(4 << 16), 32'd0);
        queue_load(8'd2, 32'(3 << 16), 32'(4 << 16), 32'd0);
        queue_load(8'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_load(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        queue_start();
        queue_tick(16'd2);
        queue_tick(16'd0);
        queue_tick(16'hFFFF);
        queue_drain();
        queue_cfg(REG_TRAVEL_SPEED, 32'hFFFF_FFFF);
        queue_tick(16'hFFFF);              // step saturates, runs to the end
        queue_tick(16'd1);                 // already finished: hold
        queue_drain();
        queue_cfg(REG_POINT_COUNT, 32'd0); // acts as two points
        queue_cfg(REG_START_OFFSET, 32'h7FFF_FFFF);
        queue_cfg(REG_SNAP_FIRST, 32'd0);
        queue_start();
        queue_drain();
        queue_cfg(REG_START_OFFSET, 32'(2 << 16));
        queue_cfg(REG_SNAP_FIRST, 32'hFFFF_FFFF);
        queue_start();
        queue_tick(16'd1);

        // fill the whole table so that any point count reads written slots
        for (int i = 0; i < TABLE_DEPTH; i++)
            queue_load(8'(i), pick_coord(), pick_coord(), pick_coord());

        // random phases: reconfigure while quiet, then a start and a run of mostly ticks
        while (items_sent < ITEM_TARGET)
        begin
            queue_drain();
            if (first || $urandom_range(1))
                queue_cfg(REG_POINT_COUNT, pick_count());
            if (first || $urandom_range(1))
                queue_cfg(REG_TRAVEL_SPEED, ($urandom_range(7) == 0) ? $urandom
                                            : 32'($urandom_range(0, 8 << 16)));
            if (first || $urandom_range(1))
                queue_cfg(REG_START_OFFSET, ($urandom_range(7) == 0) ? $urandom
                                            : 32'($urandom_range(0, 30 << 16)));
            if (first || $urandom_range(1))
                queue_cfg(REG_SNAP_FIRST, $urandom);
            first = 1'b0;
            repeat ($urandom_range(0, 4))
                queue_load(8'($urandom_range(0, 9)), pick_coord(), pick_coord(), pick_coord());
            queue_start();
            n_steps = $urandom_range(3, 20);
            repeat (n_steps)
            begin
                case ($urandom_range(19))
                    0:       queue_load(8'($urandom), pick_coord(), pick_coord(), pick_coord());
                    1:       queue_item(CMD_UNUSED, 8'($urandom), $urandom, $urandom,
                                        $urandom, 16'($urandom));
                    2:       queue_start();
                    default: queue_tick(pick_ms());
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: item and register channels, fed from todo_q
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic        next_start;
        logic        next_cfg_valid;
        logic        calm;
        pending_op_t op;
        if (!rst_n)
        begin
            start          <= 1'b0;
            item           <= '0;
            cfg_valid      <= 1'b0;
            cfg_index      <= '0;
            cfg_data       <= '0;
            quiet_cnt      = 0;
            accepted_items = 0;
        end
        else
        begin
            next_start     = start;
            next_cfg_valid = cfg_valid;
            if (start && !busy)
            begin
                next_start = 1'b0;
                accepted_items++;
            end
            if (cfg_valid && cfg_ready)
                next_cfg_valid = 1'b0;

            // the block is quiet once nothing is in flight for a while
            if (start || busy || expected_moves.size() != 0)
                quiet_cnt = 0;
            else if (quiet_cnt < SETTLE_CYC)
                quiet_cnt++;

            // a long run in the middle with the sender never idling
            calm = (accepted_items >= 400 && accepted_items < 560);

            if (!next_start && !next_cfg_valid && todo_q.size() != 0)
            begin
                op = todo_q[0];
                case (op.kind)
                    OP_ITEM:
                    begin
                        if (calm || $urandom_range(99) >= IDLE_PCT)
                        begin
                            next_start = 1'b1;
                            item      <= op.itm;
                            void'(todo_q.pop_front());
                        end
                    end
                    OP_CFG:
                    begin
                        next_cfg_valid = 1'b1;
                        cfg_index     <= op.ridx;
                        cfg_data      <= op.data;
                        void'(todo_q.pop_front());
                    end
                    default:
                    begin
                        if (quiet_cnt >= SETTLE_CYC)
                            void'(todo_q.pop_front());
                    end
                endcase
            end
            start     <= next_start;
            cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted transaction, checks every result
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            here_x     = '0;
            here_y     = '0;
            here_z     = '0;
            aim_idx    = 1;
            odometer   = '0;
            n_points   = 9'd2;
            speed_q16  = '0;
            offset_q16 = '0;
            snap_mode  = 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                n_cfg++;
                case (cfg_index)
                    REG_POINT_COUNT:  n_points   = cfg_data[8:0];
                    REG_TRAVEL_SPEED: speed_q16  = cfg_data;
                    REG_START_OFFSET: offset_q16 = cfg_data[30:0];
                    default:          snap_mode  = cfg_data[0];
                endcase
            end
            if (done)
            begin
                if (expected_moves.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got %p", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = expected_moves.pop_front();
                    check_field("pos_x", 64'(want.pos_x), 64'(result.pos_x));
                    check_field("pos_y", 64'(want.pos_y), 64'(result.pos_y));
                    check_field("pos_z", 64'(want.pos_z), 64'(result.pos_z));
                    check_field("dir_x", 64'(want.dir_x), 64'(result.dir_x));
                    check_field("dir_y", 64'(want.dir_y), 64'(result.dir_y));
                    check_field("dir_z", 64'(want.dir_z), 64'(result.dir_z));
                    check_field("new_segment", 64'(want.new_segment), 64'(result.new_segment));
                    check_field("finished", 64'(want.finished), 64'(result.finished));
                    check_field("travelled", 64'(want.travelled), 64'(result.travelled));
                    n_results++;
                    n_passed += want.new_segment;
                    n_ended  += want.finished;
                end
            end
            // predict after the result check so a same-edge result is not confused
            if (start && !busy)
            begin
                case (item.cmd)
                    CMD_LOAD:  n_loads++;
                    CMD_START: n_starts++;
                    CMD_TICK:  n_ticks++;
                    default:   ;
                endcase
                if (predict_move(item, want))
                    expected_moves.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: no transaction of any kind for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || done)
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_moves.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------------
    initial
    begin
        mismatches = 0;
        n_loads    = 0;
        n_starts   = 0;
        n_ticks    = 0;
        n_results  = 0;
        n_passed   = 0;
        n_ended    = 0;
        n_cfg      = 0;
        stall_cnt  = 0;
        @(posedge rst_n);
        while (todo_q.size() != 0 || start || cfg_valid || expected_moves.size() != 0)
            @(posedge clk);
        // room for a stray result after the last expected one
        repeat (300) @(posedge clk);
        if (expected_moves.size() != 0)
        begin
            $display("%0t: %0d expected results never came", $time, expected_moves.size());
            mismatches++;
        end
        $display("Covered %0d loads, %0d starts, %0d ticks, %0d register writes;",
                 n_loads, n_starts, n_ticks, n_cfg);
        $display("%0d moves checked, %0d passed a waypoint, %0d at path end.",
                 n_results, n_passed, n_ended);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pwf_pkg.sv
rtl/polyline_waypoint_follower.sv
tb/tb_polyline_waypoint_follower.sv
